@@ rtl/assert_macros.svh @@
// assertion macros for the rtl of the moving average block
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define TAMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition implies another one in the next cycle
`define TAMA_ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

@@ rtl/tama_pkg.sv @@
// types and constants of the three-axis moving average block
// no dependencies; used by three_axis_moving_average_unit and its testbench
package tama_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int OFF_W      = 17;
  localparam int WIN_W      = 6;
  localparam int CFG_DATA_W = 17;

  localparam logic [WIN_W-1:0] WIN_RESET = 6'd16;

  typedef enum logic [1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_OFFSET_X   = 2'd1,
    CFG_OFFSET_Y   = 2'd2,
    CFG_OFFSET_Z   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg_x;
    logic signed [SAMPLE_W-1:0] avg_y;
    logic signed [SAMPLE_W-1:0] avg_z;
    logic                       clipped;
  } out_item_t;

endpackage

@@ rtl/three_axis_moving_average_unit.sv @@
// three-axis boxcar moving average with calibration offset and saturation
// depends on tama_pkg and assert_macros.svh
//
// channel  direction  handshake              payload
// in_      input      in_valid / in_stall    tama_pkg::in_item_t
// out_     output     out_valid / out_stall  tama_pkg::out_item_t
// cfg_     input      cfg_valid / cfg_ready  cfg_addr, cfg_data
//
// an item that gives a result passes SUB, ADD, LOAD, DIV, SIGN and FIN before the block
// is free again, one that only fills the ring just SUB and ADD; in DIV the bit-serial
// divider makes one quotient bit per cycle for all three axes
// a finished result waits in the output register while the next item is taken;
// the next result is held back while that register is still stalled
// reset is synchronous: window length 16, offsets 0, ring empty; config only when idle
`include "assert_macros.svh"

module three_axis_moving_average_unit #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tama_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tama_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  tama_pkg::cfg_idx_t                cfg_addr,
  input  logic [tama_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW    = tama_pkg::SAMPLE_W;
  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int W_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SW + PW + 1;
  localparam int CW    = $clog2(SUM_W + 1);
  localparam int RW    = SUM_W + 3;

  localparam logic signed [RW-1:0] SAT_HI = RW'((2 ** (SW - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_LOAD,
    ST_DIV,
    ST_SIGN,
    ST_FIN
  } state_t;

  state_t                           state_r, state_nxt;
  logic [tama_pkg::WIN_W-1:0]       win_r, win_nxt;
  logic signed [tama_pkg::OFF_W-1:0] off_r [3];
  logic signed [tama_pkg::OFF_W-1:0] off_nxt [3];
  logic signed [SUM_W-1:0]          sum_r [3];
  logic signed [SUM_W-1:0]          sum_nxt [3];
  logic [PW-1:0]                    pos_r, pos_nxt;
  logic [W_W-1:0]                   fill_r, fill_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  tama_pkg::out_item_t              out_data_r, out_data_nxt;

  // divider lanes: dividend shifts out at the top, quotient bits enter below
  logic [SUM_W-1:0]                 dvd_r [3];
  logic [SUM_W-1:0]                 dvd_nxt [3];
  logic [W_W-1:0]                   rem_r [3];
  logic [W_W-1:0]                   rem_nxt [3];
  logic                             neg_r [3];
  logic                             neg_nxt [3];
  logic signed [SUM_W:0]            q_r [3];
  logic signed [SUM_W:0]            q_nxt [3];

  tama_pkg::in_item_t               ring_r [MAX_WINDOW];
  tama_pkg::in_item_t               smp_r;
  tama_pkg::in_item_t               old_r;

  logic [W_W-1:0]                   w_eff;
  logic                             in_acc;
  logic                             cfg_acc;
  logic signed [SW-1:0]             smp_a [3];
  logic signed [SW-1:0]             old_a [3];

  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign smp_a[0] = smp_r.sample_x;
  assign smp_a[1] = smp_r.sample_y;
  assign smp_a[2] = smp_r.sample_z;
  assign old_a[0] = old_r.sample_x;
  assign old_a[1] = old_r.sample_y;
  assign old_a[2] = old_r.sample_z;

  // window length zero acts as one, above the ring depth as the depth
  always_comb begin
    if (win_r == '0) begin
      w_eff = W_W'(1);
    end else if (int'(win_r) > MAX_WINDOW) begin
      w_eff = W_W'(MAX_WINDOW);
    end else begin
      w_eff = W_W'(win_r);
    end
  end

  always_comb begin
    logic [W_W:0]            rs;
    logic [W_W:0]            wz;
    logic [PW:0]             pos_inc;
    logic signed [RW-1:0]    r_v;
    logic signed [SW-1:0]    res [3];
    logic                    clip;

    state_nxt     = state_r;
    win_nxt       = win_r;
    off_nxt       = off_r;
    sum_nxt       = sum_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    q_nxt         = q_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    rs            = '0;
    wz            = {1'b0, w_eff};
    pos_inc       = {1'b0, pos_r} + (PW + 1)'(1);
    r_v           = '0;
    clip          = 1'b0;
    for (int a = 0; a < 3; a++) begin
      res[a] = '0;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          unique case (cfg_addr)
            tama_pkg::CFG_WINDOW_LEN: win_nxt = cfg_data[tama_pkg::WIN_W-1:0];
            tama_pkg::CFG_OFFSET_X:   off_nxt[0] = $signed(cfg_data[tama_pkg::OFF_W-1:0]);
            tama_pkg::CFG_OFFSET_Y:   off_nxt[1] = $signed(cfg_data[tama_pkg::OFF_W-1:0]);
            tama_pkg::CFG_OFFSET_Z:   off_nxt[2] = $signed(cfg_data[tama_pkg::OFF_W-1:0]);
          endcase
          // any register write restarts filling
          for (int a = 0; a < 3; a++) begin
            sum_nxt[a] = '0;
          end
          pos_nxt  = '0;
          fill_nxt = '0;
        end else if (in_acc) begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        // drop the oldest sample once the window is full
        if (fill_r >= w_eff) begin
          for (int a = 0; a < 3; a++) begin
            sum_nxt[a] = sum_r[a] - SUM_W'(old_a[a]);
          end
        end else begin
          fill_nxt = fill_r + W_W'(1);
        end
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        for (int a = 0; a < 3; a++) begin
          sum_nxt[a] = sum_r[a] + SUM_W'(smp_a[a]);
        end
        if (int'(pos_inc) >= int'(w_eff)) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_inc[PW-1:0];
        end
        if (fill_r < w_eff) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        for (int a = 0; a < 3; a++) begin
          neg_nxt[a] = sum_r[a][SUM_W-1];
          dvd_nxt[a] = sum_r[a][SUM_W-1] ? SUM_W'(-sum_r[a]) : SUM_W'(sum_r[a]);
          rem_nxt[a] = '0;
        end
        cnt_nxt   = CW'(SUM_W);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // restoring division of the magnitude, one quotient bit per cycle
        for (int a = 0; a < 3; a++) begin
          rs = {rem_r[a], dvd_r[a][SUM_W-1]};
          if (rs >= wz) begin
            rs         = rs - wz;
            dvd_nxt[a] = {dvd_r[a][SUM_W-2:0], 1'b1};
          end else begin
            dvd_nxt[a] = {dvd_r[a][SUM_W-2:0], 1'b0};
          end
          rem_nxt[a] = rs[W_W-1:0];
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        // truncation toward zero: sign goes back on the magnitude quotient
        for (int a = 0; a < 3; a++) begin
          q_nxt[a] = neg_r[a] ? -$signed({1'b0, dvd_r[a]}) : $signed({1'b0, dvd_r[a]});
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          for (int a = 0; a < 3; a++) begin
            r_v = RW'(q_r[a]) - RW'(off_r[a]);
            if (r_v > SAT_HI) begin
              res[a] = SAT_HI[SW-1:0];
              clip   = 1'b1;
            end else if (r_v < SAT_LO) begin
              res[a] = SAT_LO[SW-1:0];
              clip   = 1'b1;
            end else begin
              res[a] = r_v[SW-1:0];
            end
          end
          out_data_nxt.avg_x   = res[0];
          out_data_nxt.avg_y   = res[1];
          out_data_nxt.avg_z   = res[2];
          out_data_nxt.clipped = clip;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sample ring: old entry read before the new transaction overwrites it
  always_ff @(posedge clk) begin
    if (in_acc) begin
      old_r          <= ring_r[pos_r];
      ring_r[pos_r]  <= in_data;
      smp_r          <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= tama_pkg::WIN_RESET;
      pos_r       <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        off_r[a] <= '0;
        sum_r[a] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      off_r       <= off_nxt;
      sum_r       <= sum_nxt;
    end
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

  `TAMA_ASSERT(a_fill_in_window, fill_r <= w_eff, "fill count beyond window length")
  `TAMA_ASSERT(a_pos_in_window, int'(pos_r) < int'(w_eff), "ring position beyond window")
  `TAMA_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_SUB, "transaction not started")
  `TAMA_ASSERT_NEXT(a_div_ends, state_r == ST_DIV && cnt_r == CW'(1), state_r == ST_SIGN, "divider overran")

endmodule

@@ sim/three_axis_moving_average_unit_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for three_axis_moving_average_unit: directed table, then random bursts
// depends on tama_pkg and the rtl; every average is checked against a typed table value or a boxcar model kept here

module three_axis_moving_average_unit_tb;
  import tama_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RING_DEPTH    = 32;
  localparam int SETTLE        = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_SAMPLES = 525;
  localparam int NROWS         = 20;
  localparam longint AVG_MAX   = 2 ** (SAMPLE_W - 1) - 1;
  localparam longint AVG_MIN   = -AVG_MAX - 1;

  // sender idle and receiver stall odds per phase, plus the window each phase opens with
  localparam int SEND_IDLE [3] = '{24, 77, 0};
  localparam int RECV_IDLE [3] = '{77, 24, 0};
  localparam logic [CFG_DATA_W-1:0] PHASE_WIN [3] = '{17'h1FFFF, 17'h00020, 17'h0AAC4};

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    int                    reps;
    cfg_idx_t              addr;
    logic [CFG_DATA_W-1:0] data;
    int                    x, y, z;
    bit                    typed;
    int                    ex, ey, ez, eclip;
  } row_t;

  // window starts at its reset length of 16, offsets at 0
  row_t plan [NROWS] = '{
    '{ROW_SAMPLE, 16, CFG_WINDOW_LEN, 17'h0, 32767, -32768, 100, 1, 32767, -32768, 100, 0},
    '{ROW_WRITE,   1, CFG_WINDOW_LEN, 17'h1FFC1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE,  1, CFG_WINDOW_LEN, 17'h0, 32767, -32768, 0, 1, 32767, -32768, 0, 0},
    '{ROW_WRITE,   1, CFG_OFFSET_X, 17'h10000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE,  1, CFG_WINDOW_LEN, 17'h0, 0, 0, 0, 1, 32767, 0, 0, 1},
    '{ROW_WRITE,   1, CFG_OFFSET_Y, 17'h0FFFF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE,   1, CFG_OFFSET_Z, 17'h00001, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE,  1, CFG_WINDOW_LEN, 17'h0, 1, -1, -32768, 1, 32767, -32768, -32768, 1},
    '{ROW_SAMPLE,  1, CFG_WINDOW_LEN, 17'h0, -32768, 32767, 32767, 1, 32767, -32768, 32766, 1},
    '{ROW_WRITE,   1, CFG_OFFSET_Y, 17'h00000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE,   1, CFG_OFFSET_Z, 17'h00000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE,   1, CFG_OFFSET_X, 17'h1FFFF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE,  1, CFG_WINDOW_LEN, 17'h0, 32766, 32767, -32768, 1, 32767, 32767, -32768, 0},
    '{ROW_WRITE,   1, CFG_OFFSET_X, 17'h00000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE,   1, CFG_WINDOW_LEN, 17'h00000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE,  1, CFG_WINDOW_LEN, 17'h0, 5, -5, 7, 1, 5, -5, 7, 0},
    '{ROW_WRITE,   1, CFG_WINDOW_LEN, 17'h00002, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE,  1, CFG_WINDOW_LEN, 17'h0, 1, -1, 3, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE,  1, CFG_WINDOW_LEN, 17'h0, -2, -2, -4, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE,  1, CFG_WINDOW_LEN, 17'h0, 7, 5, -9, 0, 0, 0, 0, 0}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_addr  = CFG_WINDOW_LEN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // boxcar state mirrored from the block
  logic [WIN_W-1:0]           win_len;
  logic signed [OFF_W-1:0]    cal_off [3];
  logic signed [SAMPLE_W-1:0] hist [3][RING_DEPTH];
  longint                     win_sum [3];
  int                         slot, filled;

  out_item_t avg_q [$];
  out_item_t want_avg;
  int        in_gap_pct, stall_pct;
  int        fails = 0, cycles = 0;
  int        n_samples = 0, n_avgs = 0, n_clipped = 0, n_writes = 0;

  three_axis_moving_average_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int active_window();
    if (win_len == 0) return 1;
    if (win_len > RING_DEPTH) return RING_DEPTH;
    return int'(win_len);
  endfunction

  function automatic void clear_window();
    for (int a = 0; a < 3; a++) win_sum[a] = 0;
    slot   = 0;
    filled = 0;
  endfunction

  // any register write restarts the fill, offsets included
  function automatic void apply_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_WINDOW_LEN: win_len = d[WIN_W-1:0];
      CFG_OFFSET_X:   cal_off[0] = d;
      CFG_OFFSET_Y:   cal_off[1] = d;
      CFG_OFFSET_Z:   cal_off[2] = d;
    endcase
    clear_window();
  endfunction

  function automatic bit boxcar_step(in_item_t s, output out_item_t avg);
    int                         w, p;
    longint                     smp [3];
    longint                     r;
    logic signed [SAMPLE_W-1:0] res [3];
    bit                         clip;
    w      = active_window();
    p      = slot % RING_DEPTH;
    smp[0] = $signed(s.sample_x);
    smp[1] = $signed(s.sample_y);
    smp[2] = $signed(s.sample_z);
    clip   = 1'b0;
    avg    = '0;
    if (filled >= w) begin
      for (int a = 0; a < 3; a++) win_sum[a] -= hist[a][p];
    end else begin
      filled++;
    end
    for (int a = 0; a < 3; a++) begin
      hist[a][p] = smp[a][SAMPLE_W-1:0];
      win_sum[a] += smp[a];
    end
    slot = (p + 1 >= w) ? 0 : p + 1;
    if (filled < w) return 1'b0;
    for (int a = 0; a < 3; a++) begin
      // division truncates toward zero
      r = win_sum[a] / w - cal_off[a];
      if (r > AVG_MAX) begin
        r    = AVG_MAX;
        clip = 1'b1;
      end
      if (r < AVG_MIN) begin
        r    = AVG_MIN;
        clip = 1'b1;
      end
      res[a] = r[SAMPLE_W-1:0];
    end
    avg.avg_x   = res[0];
    avg.avg_y   = res[1];
    avg.avg_z   = res[2];
    avg.clipped = clip;
    return 1'b1;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(5))
      0:       return 17'h10000;
      1:       return 17'h0FFFF;
      2:       return '0;
      3:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // upper data bits are random, the block keeps only the low six
  function automatic logic [CFG_DATA_W-1:0] pick_window();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(9))
      0:       d[WIN_W-1:0] = '0;
      1:       d[WIN_W-1:0] = 6'd1;
      2:       d[WIN_W-1:0] = 6'd32;
      3:       d[WIN_W-1:0] = WIN_W'($urandom_range(33, 63));
      4, 5, 6: d[WIN_W-1:0] = WIN_W'($urandom_range(1, 8));
      default: d[WIN_W-1:0] = WIN_W'($urandom_range(1, 32));
    endcase
    return d;
  endfunction

  // mode 0 full range, 1 near the rails, else small values
  function automatic in_item_t pick_sample(int mode);
    logic signed [SAMPLE_W-1:0] v [3];
    in_item_t                   s;
    for (int a = 0; a < 3; a++) begin
      case (mode)
        0: v[a] = SAMPLE_W'($urandom);
        1: v[a] = $urandom_range(1) ? 16'sh7fff - SAMPLE_W'($urandom_range(3))
                                    : 16'sh8000 + SAMPLE_W'($urandom_range(3));
        default: v[a] = SAMPLE_W'(int'($urandom_range(0, 600)) - 300);
      endcase
    end
    s.sample_x = v[0];
    s.sample_y = v[1];
    s.sample_z = v[2];
    return s;
  endfunction

  task automatic check_field(string name, input logic signed [SAMPLE_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic send_sample(in_item_t s, bit typed, out_item_t typed_avg);
    out_item_t avg;
    int        idle;
    if ($urandom_range(99) < in_gap_pct) begin
      idle = 1;
      while ($urandom_range(99) < in_gap_pct) idle++;
      // now and then a longer gap, at times long enough to cover a whole item
      if ($urandom_range(19) == 0) idle += $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    n_samples++;
    if (boxcar_step(s, avg)) avg_q.push_back(typed ? typed_avg : avg);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (avg_q.size() != 0);
  endtask

  // items that do not yet complete a fill give nothing, so let the block finish before writing
  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    wait_results();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, d);
    n_writes++;
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (avg_q.size() == 0) begin
        $error("average transaction with none outstanding");
        fails++;
      end else begin
        want_avg = avg_q.pop_front();
        check_field("avg_x", want_avg.avg_x, out_data.avg_x);
        check_field("avg_y", want_avg.avg_y, out_data.avg_y);
        check_field("avg_z", want_avg.avg_z, out_data.avg_z);
        check_field("clipped", want_avg.clipped, out_data.clipped);
        n_avgs++;
        if (want_avg.clipped) n_clipped++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t  s;
    out_item_t typed_avg;
    cfg_idx_t  idx;
    logic [3:0] mask;
    int        burst, mode, sent;
    win_len = WIN_RESET;
    for (int a = 0; a < 3; a++) begin
      cal_off[a] = '0;
      for (int k = 0; k < RING_DEPTH; k++) hist[a][k] = '0;
    end
    clear_window();
    in_gap_pct = SEND_IDLE[0];
    stall_pct  = RECV_IDLE[0];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_register(plan[i].addr, plan[i].data);
      end else begin
        s.sample_x          = SAMPLE_W'(plan[i].x);
        s.sample_y          = SAMPLE_W'(plan[i].y);
        s.sample_z          = SAMPLE_W'(plan[i].z);
        typed_avg.avg_x     = SAMPLE_W'(plan[i].ex);
        typed_avg.avg_y     = SAMPLE_W'(plan[i].ey);
        typed_avg.avg_z     = SAMPLE_W'(plan[i].ez);
        typed_avg.clipped   = plan[i].eclip[0];
        repeat (plan[i].reps) send_sample(s, plan[i].typed, typed_avg);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      in_gap_pct = SEND_IDLE[ph];
      stall_pct  = RECV_IDLE[ph];
      write_register(CFG_WINDOW_LEN, PHASE_WIN[ph]);
      write_register(CFG_OFFSET_X, pick_offset());
      write_register(CFG_OFFSET_Y, pick_offset());
      write_register(CFG_OFFSET_Z, pick_offset());
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        if (sent > 0) begin
          mask = 4'($urandom_range(1, 15));
          for (int r = 0; r < 4; r++) begin
            idx = cfg_idx_t'(r);
            if (mask[r]) write_register(idx, idx == CFG_WINDOW_LEN ? pick_window() : pick_offset());
          end
        end
        // some bursts stop short of a full window
        burst = $urandom_range(1, active_window() + 40);
        mode  = $urandom_range(2);
        repeat (burst) begin
          send_sample(pick_sample(mode), 1'b0, '0);
          sent++;
          if (sent == PHASE_SAMPLES / 2 || $urandom_range(199) == 0) wait_results();
        end
      end
    end

    wait_results();
    repeat (SETTLE) @(posedge clk);
    $display("%0d samples sent, %0d averages checked (%0d saturated), %0d register writes",
             n_samples, n_avgs, n_clipped, n_writes);
    $display("pacing covered: sender/receiver idle 24/77, then 77/24, then none");
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
